/* design/rrt_tree_extend_macros.svh */
// ----------------------------------------------------------------------------
// RRT tree extension assertion macros
// Shared assertion forms for the checker of the tree extension block.
// ----------------------------------------------------------------------------
`ifndef RRT_TREE_EXTEND_MACROS_SVH
`define RRT_TREE_EXTEND_MACROS_SVH

// Implication checked every clock while out of reset.
`define RRT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication checked every clock while out of reset.
`define RRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* design/rrt_pkg.sv */
// ----------------------------------------------------------------------------
// RRT package
// Types and constants shared by the tree extension block.
// ----------------------------------------------------------------------------
package rrt_pkg;

	localparam int CoordW = 16;
	localparam int IdxW   = 10;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 16;

	localparam logic [1:0] ST_ADDED   = 2'd0;
	localparam logic [1:0] ST_GOAL    = 2'd1;
	localparam logic [1:0] ST_REFUSED = 2'd2;
	localparam logic [1:0] ST_RESTART = 2'd3;

	localparam logic [CfgIdxW-1:0] REG_SOURCE_X = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_SOURCE_Y = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_TARGET_X = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_TARGET_Y = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_GOAL_HX  = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_GOAL_HY  = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_STEP     = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_MAX      = 3'd7;

	typedef struct packed {
		logic                     kind;
		logic signed [CoordW-1:0] sample_x;
		logic signed [CoordW-1:0] sample_y;
	} in_item_t;

	typedef struct packed {
		logic [1:0]               status;
		logic [IdxW-1:0]          node_index;
		logic [IdxW-1:0]          parent_index;
		logic signed [CoordW-1:0] new_x;
		logic signed [CoordW-1:0] new_y;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_SCAN_DRAIN,
		S_SQRT,
		S_MULT,
		S_DIV,
		S_ADD,
		S_GOAL,
		S_WRITE
	} state_t;

endpackage

/* design/rrt_ram.sv */
// ----------------------------------------------------------------------------
// RRT generic RAM
// Single-port-write, single-port-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module rrt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* design/rrt_tree_extend.sv */
// ----------------------------------------------------------------------------
// RRT tree extension
// The nearest-node scan reads one node per cycle from the node memory and then
// passes through a drain state for the registered read. A bit-serial square
// root follows. A bit-serial divider forms each of the two offsets in a load
// state and a divide state. Writing the new node back passes through the add,
// goal and write states. A sample that lies on its nearest node skips the
// square root and the divides. Restart and refusal keep busy high for one
// cycle, the result cycle. One item is in work at a time. The result appears
// on out_item with done high for one cycle. The receiver cannot hold it off.
// ----------------------------------------------------------------------------
module rrt_tree_extend #(
	parameter int NODE_CAPACITY = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  rrt_pkg::in_item_t               in_item,
	output logic                            done,
	output rrt_pkg::out_item_t              out_item,
	input  logic                            cfg_we,
	input  logic [rrt_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [rrt_pkg::CfgDataW-1:0]    cfg_data
);

	import rrt_pkg::*;

	localparam int AW = $clog2(NODE_CAPACITY);
	localparam int CW = AW + 1;

	logic signed [CoordW-1:0] src_x_q, src_y_q, tgt_x_q, tgt_y_q;
	logic [14:0] ghx_q, ghy_q, step_q;
	logic [10:0] maxn_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_x_q <= '0;
			src_y_q <= '0;
			tgt_x_q <= '0;
			tgt_y_q <= '0;
			ghx_q   <= 15'd256;
			ghy_q   <= 15'd256;
			step_q  <= 15'd256;
			maxn_q  <= 11'd1024;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SOURCE_X: src_x_q <= cfg_data;
				REG_SOURCE_Y: src_y_q <= cfg_data;
				REG_TARGET_X: tgt_x_q <= cfg_data;
				REG_TARGET_Y: tgt_y_q <= cfg_data;
				REG_GOAL_HX:  ghx_q   <= cfg_data[14:0];
				REG_GOAL_HY:  ghy_q   <= cfg_data[14:0];
				REG_STEP:     step_q  <= cfg_data[14:0];
				REG_MAX:      maxn_q  <= cfg_data[10:0];
				default:      ;
			endcase
		end
	end

	state_t state_q, state_d;

	logic [CW-1:0] count_q;
	logic          goal_q;
	logic signed [CoordW-1:0] sx_q, sy_q;
	logic [CW-1:0] rd_idx_q;
	logic [CW-1:0] cmp_idx_s1;
	logic          cmp_vld_s1;
	logic [AW-1:0] best_q;
	logic [33:0]   best_d2_q;
	logic signed [CoordW-1:0] px_q, py_q;
	logic [33:0]   rem_q;
	logic [16:0]   root_q;
	logic [33:0]   sq_v_q;
	logic [4:0]    cnt_q;
	logic          axis_q;
	logic [32:0]   dvq_q;
	logic [17:0]   drem_q;
	logic signed [CoordW+1:0] ofs_x_q, ofs_y_q;
	logic signed [CoordW-1:0] nx_q, ny_q;
	logic          doned_q;
	out_item_t     out_q;

	logic [AW-1:0] raddr;
	logic signed [CoordW-1:0] rx, ry;
	logic          we;

	logic [CW-1:0] limit;
	assign limit = (int'(maxn_q) > NODE_CAPACITY) ? CW'(NODE_CAPACITY)
		: CW'(maxn_q);

	assign raddr = rd_idx_q[AW-1:0];

	rrt_ram #(.WIDTH(CoordW), .DEPTH(NODE_CAPACITY)) u_ram_x (
		.clk(clk), .we(we), .waddr(count_q[AW-1:0]), .wdata(nx_q),
		.raddr(raddr), .rdata(rx)
	);

	rrt_ram #(.WIDTH(CoordW), .DEPTH(NODE_CAPACITY)) u_ram_y (
		.clk(clk), .we(we), .waddr(count_q[AW-1:0]), .wdata(ny_q),
		.raddr(raddr), .rdata(ry)
	);

	logic signed [CoordW-1:0] cx, cy;
	logic signed [CoordW:0]   cdx, cdy;
	logic [33:0] cd2;
	logic        cmp_win;
	logic [33:0] fin_d2;
	assign cx  = (cmp_idx_s1 == '0) ? src_x_q : rx;
	assign cy  = (cmp_idx_s1 == '0) ? src_y_q : ry;
	assign cdx = 17'(sx_q) - 17'(cx);
	assign cdy = 17'(sy_q) - 17'(cy);
	assign cd2 = 34'(cdx * cdx) + 34'(cdy * cdy);
	assign cmp_win = cmp_vld_s1 && (cmp_idx_s1 == '0 || cd2 < best_d2_q);
	assign fin_d2  = cmp_win ? cd2 : best_d2_q;

	logic signed [CoordW:0] pdx, pdy, dsel;
	logic [16:0] dabs;
	assign pdx  = 17'(sx_q) - 17'(px_q);
	assign pdy  = 17'(sy_q) - 17'(py_q);
	assign dsel = axis_q ? pdy : pdx;
	assign dabs = dsel[16] ? 17'(-dsel) : 17'(dsel);

	logic [35:0] sq_t;
	logic [33:0] sq_bit;
	assign sq_bit = 34'(1) << {cnt_q, 1'b0};
	assign sq_t = 36'(sq_v_q) - 36'(rem_q) - 36'(sq_bit);

	logic [18:0] dv_try;
	assign dv_try = {drem_q, dvq_q[32]} - 19'(root_q);

	logic signed [CoordW+2:0] sum_x, sum_y;
	logic signed [CoordW-1:0] sat_x, sat_y;
	localparam logic signed [CoordW+2:0] CMAX = (19'sd1 <<< (CoordW-1)) - 19'sd1;
	localparam logic signed [CoordW+2:0] CMIN = -(19'sd1 <<< (CoordW-1));
	assign sum_x = 19'(px_q) + 19'(ofs_x_q);
	assign sum_y = 19'(py_q) + 19'(ofs_y_q);
	assign sat_x = (sum_x > CMAX) ? CoordW'(CMAX) : (sum_x < CMIN) ? CoordW'(CMIN)
		: CoordW'(sum_x);
	assign sat_y = (sum_y > CMAX) ? CoordW'(CMAX) : (sum_y < CMIN) ? CoordW'(CMIN)
		: CoordW'(sum_y);

	logic signed [CoordW:0] gdx, gdy;
	logic [16:0] gax, gay;
	logic        in_goal;
	assign gdx = 17'(nx_q) - 17'(tgt_x_q);
	assign gdy = 17'(ny_q) - 17'(tgt_y_q);
	assign gax = gdx[16] ? 17'(-gdx) : 17'(gdx);
	assign gay = gdy[16] ? 17'(-gdy) : 17'(gdy);
	assign in_goal = (gax < 17'(ghx_q)) && (gay < 17'(ghy_q));

	logic accept;
	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE) || doned_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && !in_item.kind && !goal_q && count_q < limit) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN:       if (rd_idx_q == count_q - CW'(1)) state_d = S_SCAN_DRAIN;
			S_SCAN_DRAIN: state_d = (fin_d2 == '0) ? S_ADD : S_SQRT;
			S_SQRT:       if (cnt_q == '0) state_d = S_MULT;
			S_MULT:       state_d = S_DIV;
			S_DIV:        if (cnt_q == 5'd31) state_d = axis_q ? S_ADD : S_MULT;
			S_ADD:        state_d = S_GOAL;
			S_GOAL:       state_d = S_WRITE;
			S_WRITE:      state_d = S_IDLE;
			default:      state_d = S_IDLE;
		endcase
	end

	assign we = (state_q == S_WRITE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= CW'(1);
			goal_q     <= 1'b0;
			cmp_vld_s1 <= 1'b0;
			doned_q    <= 1'b0;
		end else begin
			state_q    <= state_d;
			doned_q    <= 1'b0;
			cmp_vld_s1 <= (state_q == S_SCAN);
			if (accept && in_item.kind) begin
				count_q <= CW'(1);
				goal_q  <= 1'b0;
				doned_q <= 1'b1;
			end else if (accept && state_d == S_IDLE) begin
				doned_q <= 1'b1;
			end
			if (state_q == S_WRITE) begin
				count_q <= count_q + CW'(1);
				goal_q  <= out_q.status == ST_GOAL;
				doned_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				sx_q     <= in_item.sample_x;
				sy_q     <= in_item.sample_y;
				rd_idx_q <= '0;
				best_d2_q <= '0;
				best_q   <= '0;
				if (accept) begin
					if (in_item.kind) begin
						out_q <= '{status: ST_RESTART, node_index: '0, parent_index: '0,
							new_x: src_x_q, new_y: src_y_q};
					end else begin
						out_q <= '{status: ST_REFUSED, node_index: '0, parent_index: '0,
							new_x: '0, new_y: '0};
					end
				end
			end
			S_SCAN: rd_idx_q <= rd_idx_q + CW'(1);
			default: ;
		endcase
		cmp_idx_s1 <= rd_idx_q;
		if (cmp_win) begin
			best_d2_q <= cd2;
			best_q    <= cmp_idx_s1[AW-1:0];
			px_q      <= cx;
			py_q      <= cy;
		end
		if (state_q == S_SCAN_DRAIN) begin
			sq_v_q <= fin_d2;
			rem_q  <= '0;
			cnt_q  <= 5'd16;
			axis_q <= 1'b0;
			ofs_x_q <= '0;
			ofs_y_q <= '0;
		end
		if (state_q == S_SQRT) begin
			if (!sq_t[35]) begin
				sq_v_q <= sq_t[33:0];
				rem_q  <= (rem_q >> 1) + sq_bit;
			end else begin
				rem_q  <= rem_q >> 1;
			end
			cnt_q <= cnt_q - 5'd1;
		end
		if (state_q == S_MULT) begin
			root_q <= rem_q[16:0];
			dvq_q  <= {32'(dabs * step_q) + 32'(rem_q[16:1]), 1'b0};
			drem_q <= '0;
			cnt_q  <= 5'd0;
		end
		if (state_q == S_DIV) begin
			drem_q <= dv_try[18] ? {drem_q[16:0], dvq_q[32]} : dv_try[17:0];
			dvq_q  <= {dvq_q[31:0], ~dv_try[18]};
			cnt_q  <= cnt_q + 5'd1;
		end
		if (state_q == S_ADD) begin
			nx_q <= sat_x;
			ny_q <= sat_y;
		end
		if (state_q == S_GOAL) begin
			out_q.status       <= in_goal ? ST_GOAL : ST_ADDED;
			out_q.node_index   <= IdxW'(count_q);
			out_q.parent_index <= IdxW'(best_q);
			out_q.new_x        <= nx_q;
			out_q.new_y        <= ny_q;
		end
		if (state_q == S_DIV && cnt_q == 5'd31) begin
			if (!axis_q) begin
				ofs_x_q <= pdx[16] ? -18'({dvq_q[15:0], ~dv_try[18]})
					: 18'({dvq_q[15:0], ~dv_try[18]});
			end else begin
				ofs_y_q <= pdy[16] ? -18'({dvq_q[15:0], ~dv_try[18]})
					: 18'({dvq_q[15:0], ~dv_try[18]});
			end
			axis_q <= 1'b1;
		end
	end

	assign done     = doned_q;
	assign out_item = out_q;

endmodule

/* design/rrt_chk.sv */
// ----------------------------------------------------------------------------
// RRT port checker
// Watches the ports of the tree extension block and checks its handshake.
// ----------------------------------------------------------------------------
`include "rrt_tree_extend_macros.svh"

module rrt_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input rrt_pkg::in_item_t   in_item,
	input rrt_pkg::out_item_t  out_item
);

	import rrt_pkg::*;

	`RRT_ASSERT_NEXT(a_acc_busy, clk, arst_n, start && !busy, busy)
	`RRT_ASSERT_NEXT(a_done_once, clk, arst_n, done, !done)
	`RRT_ASSERT_IMPL(a_done_busy, clk, arst_n, done, busy)
	`RRT_ASSERT_NEXT(a_restart, clk, arst_n, start && !busy && in_item.kind,
		done && out_item.status == ST_RESTART)

endmodule

bind rrt_tree_extend rrt_chk u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.in_item(in_item), .out_item(out_item)
);

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RRT tree extension testbench
// Drives restart and extend commands into the tree extension block, keeps a
// predictor of the node store and its configuration, and checks every result
// transfer field by field against the oldest expected result.
// ----------------------------------------------------------------------------
module tb_top;
	import rrt_pkg::*;

	localparam int Capacity = 1024;
	localparam int IdleLimit = 6000;
	localparam int ItemTarget = 540;
	localparam int QuietTail = 60;

	typedef struct {
		bit                  is_cfg;
		logic [CfgIdxW-1:0]  reg_idx;
		logic [CfgDataW-1:0] data;
		in_item_t            item;
		bit                  fixed;
		out_item_t           want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_item_t in_item;
	logic done;
	out_item_t out_item;
	logic cfg_we;
	logic [CfgIdxW-1:0] cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	rrt_tree_extend dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_item(in_item),
		.done(done), .out_item(out_item), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	logic signed [15:0] src_x, src_y, tgt_x, tgt_y;
	logic [14:0] half_x, half_y, step_q;
	logic [10:0] node_limit;
	logic signed [15:0] tree_x [Capacity];
	logic signed [15:0] tree_y [Capacity];
	int unsigned tree_size;
	bit goal_hit;

	out_item_t pending_results[$];
	stim_row_t rows[$];
	int errors = 0;
	int items_sent = 0;
	int idle_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint step_offset(longint d, longint unsigned len);
		longint unsigned mag, q;
		mag = longint'(d < 0 ? -d : d) * step_q;
		q = (mag + len / 2) / len;
		return d < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint clamp_coord(longint v);
		return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
	endfunction

	function automatic void apply_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
		case (idx)
			REG_SOURCE_X: src_x = d;
			REG_SOURCE_Y: src_y = d;
			REG_TARGET_X: tgt_x = d;
			REG_TARGET_Y: tgt_y = d;
			REG_GOAL_HX: half_x = d[14:0];
			REG_GOAL_HY: half_y = d[14:0];
			REG_STEP: step_q = d[14:0];
			REG_MAX: node_limit = d[10:0];
			default: ;
		endcase
	endfunction

	function automatic out_item_t extend_tree(in_item_t it);
		out_item_t r;
		int unsigned lim, best;
		longint dx, dy, px, py, nx, ny, qx, qy;
		longint unsigned d2, best_d2, len;
		r = '0;
		lim = node_limit > Capacity ? Capacity : node_limit;
		if (it.kind) begin
			tree_size = 1;
			goal_hit = 0;
			r.status = ST_RESTART;
			r.new_x = src_x;
			r.new_y = src_y;
			return r;
		end
		if (goal_hit || tree_size >= lim || tree_size >= Capacity) begin
			r.status = ST_REFUSED;
			return r;
		end
		best = 0;
		best_d2 = 0;
		for (int unsigned i = 0; i < tree_size; i++) begin
			qx = (i == 0) ? longint'(src_x) : longint'(tree_x[i]);
			qy = (i == 0) ? longint'(src_y) : longint'(tree_y[i]);
			dx = longint'(it.sample_x) - qx;
			dy = longint'(it.sample_y) - qy;
			d2 = dx * dx + dy * dy;
			if (i == 0 || d2 < best_d2) begin
				best_d2 = d2;
				best = i;
			end
		end
		px = (best == 0) ? longint'(src_x) : longint'(tree_x[best]);
		py = (best == 0) ? longint'(src_y) : longint'(tree_y[best]);
		nx = px;
		ny = py;
		if (best_d2 != 0) begin
			len = int_sqrt(best_d2);
			nx = clamp_coord(px + step_offset(longint'(it.sample_x) - px, len));
			ny = clamp_coord(py + step_offset(longint'(it.sample_y) - py, len));
		end
		tree_x[tree_size] = nx[15:0];
		tree_y[tree_size] = ny[15:0];
		r.status = ST_ADDED;
		r.node_index = tree_size[IdxW-1:0];
		r.parent_index = best[IdxW-1:0];
		r.new_x = nx[15:0];
		r.new_y = ny[15:0];
		tree_size++;
		if ((nx - tgt_x < 0 ? tgt_x - nx : nx - tgt_x) < longint'(half_x) &&
			(ny - tgt_y < 0 ? tgt_y - ny : ny - tgt_y) < longint'(half_y)) begin
			goal_hit = 1;
			r.status = ST_GOAL;
		end
		return r;
	endfunction

	task automatic report(string field, logic [31:0] got, logic [31:0] want);
		$display("mismatch on %s: got %0h, expected %0h at %0t", field, got, want, $time);
		errors++;
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report("unexpected result", 32'(out_item.status), 32'(0));
			end else begin
				out_item_t w;
				w = pending_results.pop_front();
				if (out_item.status !== w.status)
					report("status", 32'(out_item.status), 32'(w.status));
				if (out_item.node_index !== w.node_index)
					report("node_index", 32'(out_item.node_index), 32'(w.node_index));
				if (out_item.parent_index !== w.parent_index)
					report("parent_index", 32'(out_item.parent_index), 32'(w.parent_index));
				if (out_item.new_x !== w.new_x)
					report("new_x", 32'(out_item.new_x), 32'(w.new_x));
				if (out_item.new_y !== w.new_y)
					report("new_y", 32'(out_item.new_y), 32'(w.new_y));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IdleLimit) begin
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send(in_item_t it, bit fixed, out_item_t want);
		out_item_t p;
		if (items_sent < ItemTarget - QuietTail && $urandom_range(0, 2) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		start <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (busy);
		p = extend_tree(it);
		pending_results.push_back(fixed ? want : p);
		items_sent++;
	endtask

	task automatic settle();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		apply_reg(idx, d);
	endtask

	function automatic void add_cfg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
		stim_row_t r;
		r = '{default: '0};
		r.is_cfg = 1;
		r.reg_idx = idx;
		r.data = d;
		rows.push_back(r);
	endfunction

	function automatic void add_item(logic k, logic [15:0] x, logic [15:0] y, bit fixed,
		logic [1:0] st, logic [15:0] wx, logic [15:0] wy, logic [IdxW-1:0] ni);
		stim_row_t r;
		r = '{default: '0};
		r.item.kind = k;
		r.item.sample_x = x;
		r.item.sample_y = y;
		r.fixed = fixed;
		r.want.status = st;
		r.want.node_index = ni;
		r.want.new_x = wx;
		r.want.new_y = wy;
		rows.push_back(r);
	endfunction

	function automatic logic [15:0] pick_value(logic [15:0] lo, logic [15:0] hi);
		case ($urandom_range(0, 7))
			0: return lo;
			1: return hi;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic in_item_t random_sample();
		in_item_t it;
		it.kind = ($urandom_range(0, 24) == 0);
		if ($urandom_range(0, 1)) begin
			it.sample_x = 16'($urandom);
			it.sample_y = 16'($urandom);
		end else begin
			it.sample_x = src_x + 16'($signed($urandom_range(0, 8191)) - 4096);
			it.sample_y = src_y + 16'($signed($urandom_range(0, 8191)) - 4096);
		end
		return it;
	endfunction

	initial begin
		bit last_cfg;
		int burst;
		arst_n = 1'b0;
		start = 1'b0;
		in_item = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		src_x = 0; src_y = 0; tgt_x = 0; tgt_y = 0;
		half_x = 256; half_y = 256; step_q = 256; node_limit = 1024;
		tree_size = 1;
		goal_hit = 0;

		add_item(1, 0, 0, 1, ST_RESTART, 0, 0, 0);
		add_item(0, 0, 0, 1, ST_GOAL, 0, 0, 1);
		add_item(0, 1, 1, 1, ST_REFUSED, 0, 0, 0);
		add_cfg(REG_TARGET_X, 16'h7fff);
		add_cfg(REG_TARGET_Y, 16'h8000);
		add_cfg(REG_GOAL_HX, 16'h0000);
		add_cfg(REG_GOAL_HY, 16'h7fff);
		add_item(1, 0, 0, 1, ST_RESTART, 0, 0, 0);
		add_item(0, 16'h7fff, 16'h7fff, 0, 0, 0, 0, 0);
		add_item(0, 16'h8000, 16'h8000, 0, 0, 0, 0, 0);
		add_item(0, 16'h7fff, 16'h8000, 0, 0, 0, 0, 0);
		add_item(0, 16'h8000, 16'h7fff, 0, 0, 0, 0, 0);
		add_cfg(REG_SOURCE_X, 16'h8000);
		add_cfg(REG_SOURCE_Y, 16'h7fff);
		add_cfg(REG_STEP, 16'h7fff);
		add_item(1, 16'hffff, 16'hffff, 1, ST_RESTART, 16'h8000, 16'h7fff, 0);
		add_item(0, 16'h7fff, 16'h8000, 0, 0, 0, 0, 0);
		add_item(0, 16'h8000, 16'h7fff, 0, 0, 0, 0, 0);
		add_item(0, 16'h7fff, 16'h7fff, 0, 0, 0, 0, 0);
		add_cfg(REG_MAX, 16'h0001);
		add_item(1, 0, 0, 1, ST_RESTART, 16'h8000, 16'h7fff, 0);
		add_item(0, 16'h1234, 16'h4321, 1, ST_REFUSED, 0, 0, 0);
		add_cfg(REG_MAX, 16'h0000);
		add_item(0, 16'h0100, 16'h0100, 1, ST_REFUSED, 0, 0, 0);
		add_cfg(REG_MAX, 16'h07ff);
		add_cfg(REG_STEP, 16'h0000);
		add_item(1, 0, 0, 1, ST_RESTART, 16'h8000, 16'h7fff, 0);
		add_item(0, 16'h1234, 16'hffff, 0, 0, 0, 0, 0);
		add_item(0, 16'h0000, 16'h0000, 0, 0, 0, 0, 0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		last_cfg = 0;
		foreach (rows[i]) begin
			if (rows[i].is_cfg) begin
				if (!last_cfg) settle();
				write_reg(rows[i].reg_idx, rows[i].data);
				last_cfg = 1;
			end else begin
				if (last_cfg) cfg_we <= 1'b0;
				send(rows[i].item, rows[i].fixed, rows[i].want);
				last_cfg = 0;
			end
		end

		while (items_sent < ItemTarget) begin
			settle();
			write_reg(REG_SOURCE_X, pick_value(16'h8000, 16'h7fff));
			write_reg(REG_SOURCE_Y, pick_value(16'h8000, 16'h7fff));
			write_reg(REG_TARGET_X, pick_value(16'h8000, 16'h7fff));
			write_reg(REG_TARGET_Y, pick_value(16'h8000, 16'h7fff));
			write_reg(REG_GOAL_HX, pick_value(16'h0000, 16'h7fff));
			write_reg(REG_GOAL_HY, pick_value(16'h0000, 16'h7fff));
			write_reg(REG_STEP, $urandom_range(0, 3) == 0 ? pick_value(0, 16'h7fff)
				: 16'($urandom_range(0, 2048)));
			case ($urandom_range(0, 9))
				0: write_reg(REG_MAX, 16'($urandom_range(0, 2047)));
				1: write_reg(REG_MAX, 16'h0400);
				2: write_reg(REG_MAX, 16'h07ff);
				default: write_reg(REG_MAX, 16'($urandom_range(0, 40)));
			endcase
			cfg_we <= 1'b0;
			begin
				in_item_t rst_it;
				rst_it = random_sample();
				rst_it.kind = 1'b1;
				send(rst_it, 0, '0);
			end
			burst = $urandom_range(5, 30);
			repeat (burst) send(random_sample(), 0, '0);
		end

		settle();
		repeat (100) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
